>>> hdl/nns_pkg.sv
// Shared constants and types for the nearest-neighbor image scaler.
package nns_pkg;

  // Image memory
  localparam int MEM_BYTES = 32768;
  localparam int MEM_AW    = $clog2(MEM_BYTES);

  // Dimensions and counters
  localparam int MAX_DIM = 320;
  localparam int DIM_W   = 9;
  localparam int CNT_W   = 9;
  localparam int NUM_W   = CNT_W + DIM_W;   // counter * dimension
  localparam int PROD_W  = NUM_W + DIM_W;   // source row * source width
  localparam int IDX_W   = PROD_W + 1;      // plus source column
  localparam int STEP_W  = $clog2(NUM_W);

  // Field widths
  localparam int ADDR_W  = 15;
  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 16;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_OUT_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_OUT_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SRC_WIDTH  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SRC_HEIGHT = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_PIXEL_MODE = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_FG_COLOR   = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_BG_COLOR   = 3'd6;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EMIT  = 1'b1;

  // Pixel modes
  localparam logic MODE_GRAY   = 1'b0;
  localparam logic MODE_BINARY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_READ
  } state_t;

endpackage

>>> hdl/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler: image memory, coordinate divider and pixel formatter.
//
// Usage:
//   in_*  channel (valid/stall): one transaction is either an image byte write
//         (in_req_type = write; in_byte_addr, in_byte_data) or an emit request
//         (in_req_type = emit) that produces the next output pixel in raster order.
//   out_* channel (valid/stall): one transaction per emit request, carrying the
//         RGB565 pixel plus row_end / frame_end markers.
//   cfg_* channel (valid/ready): register writes, index 0..6 = out_width,
//         out_height, src_width, src_height, pixel_mode, fg_color, bg_color.
//         cfg_ready is always high; write only while the block is idle.
// Timing:
//   Byte writes can be accepted every cycle while no emit is in progress.
//   An emit runs from acceptance through the radix-2 divider (both source
//   coordinates in parallel, one quotient bit per cycle), one multiply, one
//   add/compare with memory read and one format step into the output register.
//   Next transaction is accepted the cycle after the result is loaded.
// Reset (rst_n low, synchronous): counters to zero, registers to their
//   defaults, output empty. The image memory is not cleared.
// Stall: the finished pixel sits in the output register; a following byte
//   write is still accepted, a following emit waits in the format step.
module nearest_neighbor_image_scaler (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [nns_pkg::ADDR_W-1:0]    in_byte_addr,
  input  logic [nns_pkg::BYTE_W-1:0]    in_byte_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nns_pkg::COLOR_W-1:0]   out_pixel,
  output logic                          out_row_end,
  output logic                          out_frame_end,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nns_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [nns_pkg::CFG_DW-1:0]    cfg_data
);
  import nns_pkg::*;

  // Clamp a dimension register to 1 .. MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // One restoring-division step: returns {remainder, shifted dividend/quotient}.
  function automatic logic [DIM_W+NUM_W-1:0] div_step(
    input logic [DIM_W-1:0] rem,
    input logic [NUM_W-1:0] num,
    input logic [DIM_W-1:0] d
  );
    logic [DIM_W:0]   trial;
    logic [DIM_W-1:0] rem_o;
    logic             qbit;
    trial = {rem, num[NUM_W-1]};
    if (trial >= {1'b0, d}) begin
      rem_o = DIM_W'(trial - {1'b0, d});
      qbit  = 1'b1;
    end else begin
      rem_o = trial[DIM_W-1:0];
      qbit  = 1'b0;
    end
    return {rem_o, num[NUM_W-2:0], qbit};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]   out_width_r, out_height_r, src_width_r, src_height_r;
  logic               pixel_mode_r;
  logic [COLOR_W-1:0] fg_color_r, bg_color_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= DIM_W'(80);
      out_height_r <= DIM_W'(60);
      src_width_r  <= DIM_W'(160);
      src_height_r <= DIM_W'(120);
      pixel_mode_r <= MODE_GRAY;
      fg_color_r   <= 16'hFFFF;
      bg_color_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OUT_WIDTH:  out_width_r  <= cfg_data[DIM_W-1:0];
        CFG_OUT_HEIGHT: out_height_r <= cfg_data[DIM_W-1:0];
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[DIM_W-1:0];
        CFG_PIXEL_MODE: pixel_mode_r <= cfg_data[0];
        CFG_FG_COLOR:   fg_color_r   <= cfg_data[COLOR_W-1:0];
        CFG_BG_COLOR:   bg_color_r   <= cfg_data[COLOR_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // Effective dimensions
  logic [DIM_W-1:0] ow, oh, sw, sh;
  assign ow = dim_eff(out_width_r);
  assign oh = dim_eff(out_height_r);
  assign sw = dim_eff(src_width_r);
  assign sh = dim_eff(src_height_r);

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic in_accept, emit_go, wr_en, load_out, div_done;

  assign in_accept = in_valid && !in_stall;
  assign emit_go   = in_accept && (in_req_type == REQ_EMIT);
  assign wr_en     = in_accept && (in_req_type == REQ_WRITE);
  assign div_done  = (step_r == STEP_W'(NUM_W - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (emit_go)                   state_nxt = ST_DIV;
      ST_DIV:  if (div_done)                  state_nxt = ST_MUL;
      ST_MUL:                                 state_nxt = ST_ADD;
      ST_ADD:                                 state_nxt = ST_READ;
      ST_READ: if (!out_valid || !out_stall)  state_nxt = ST_IDLE;
      default:                                state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    load_out = (state_r == ST_READ) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIV) begin
        step_r <= div_done ? '0 : step_r + STEP_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Raster counters: advance when an emit is accepted
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] col_count_r, row_count_r;
  logic             last_col, last_row;

  assign last_col = ({1'b0, col_count_r} + (CNT_W+1)'(1)) >= {1'b0, ow};
  assign last_row = last_col && (({1'b0, row_count_r} + (CNT_W+1)'(1)) >= {1'b0, oh});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (emit_go) begin
      if (last_col) begin
        col_count_r <= '0;
        row_count_r <= last_row ? '0 : row_count_r + CNT_W'(1);
      end else begin
        col_count_r <= col_count_r + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Coordinate datapath: divide, multiply, add
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0]  num_y_r, num_x_r;     // dividends, become quotients
  logic [DIM_W-1:0]  rem_y_r, rem_x_r;
  logic [DIM_W-1:0]  div_y_r, div_x_r, sw_r;
  logic              mode_r, row_end_r, frame_end_r;
  logic [PROD_W-1:0] prod_r;
  logic [IDX_W-1:0]  idx_sum, byte_idx;
  logic              in_range_r;
  logic [2:0]        bitsel_r;
  logic [DIM_W+NUM_W-1:0] step_y, step_x;

  assign step_y   = div_step(rem_y_r, num_y_r, div_y_r);
  assign step_x   = div_step(rem_x_r, num_x_r, div_x_r);
  assign idx_sum  = IDX_W'(prod_r) + IDX_W'(num_x_r);
  assign byte_idx = (mode_r == MODE_BINARY) ? (idx_sum >> 3) : idx_sum;

  always_ff @(posedge clk) begin
    if (emit_go) begin
      num_y_r     <= NUM_W'(row_count_r) * NUM_W'(sh);
      num_x_r     <= NUM_W'(col_count_r) * NUM_W'(sw);
      rem_y_r     <= '0;
      rem_x_r     <= '0;
      div_y_r     <= oh;
      div_x_r     <= ow;
      sw_r        <= sw;
      mode_r      <= pixel_mode_r;
      row_end_r   <= last_col;
      frame_end_r <= last_row;
    end else if (state_r == ST_DIV) begin
      {rem_y_r, num_y_r} <= step_y;
      {rem_x_r, num_x_r} <= step_x;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(num_y_r) * PROD_W'(sw_r);
    end
    if (state_r == ST_ADD) begin
      in_range_r <= byte_idx < IDX_W'(MEM_BYTES);
      bitsel_r   <= idx_sum[2:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Image memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] mem [MEM_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(in_byte_addr) < 32'(MEM_BYTES))) begin
      mem[MEM_AW'(in_byte_addr)] <= in_byte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ADD) begin
      rd_data_r <= mem[byte_idx[MEM_AW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel format and output register
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]  src_byte;
  logic [COLOR_W-1:0] pix;

  assign src_byte = in_range_r ? rd_data_r : '0;

  always_comb begin
    if (mode_r == MODE_GRAY) begin
      pix = {src_byte[7:3], src_byte[7:2], src_byte[7:3]};
    end else begin
      pix = src_byte[3'd7 - bitsel_r] ? fg_color_r : bg_color_r;
    end
  end

  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_pixel_r;
  logic               out_row_end_r, out_frame_end_r;

  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pixel_r     <= pix;
      out_row_end_r   <= row_end_r;
      out_frame_end_r <= frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

>>> hdl/nns_checker.sv
// Port-level assertions for the nearest-neighbor image scaler, bound to the top level.
module nns_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_pixel,
  input logic        out_row_end,
  input logic        out_frame_end
);
  import nns_pkg::*;

  // Output register is empty after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // Frame end only on the last pixel of a row.
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame_end without row_end");

  // An accepted emit keeps the request side busy while it computes.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_EMIT) |=> in_stall)
    else $error("emit accepted without going busy");

  // A new result appears only out of an emit in progress.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an emit in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel))
    else $error("stalled result changed");

endmodule

bind nearest_neighbor_image_scaler nns_checker u_nns_checker (.*);

>>> dv/tb_nearest_neighbor_image_scaler.sv
// Self-checking testbench for the nearest-neighbor image scaler.
module tb_nearest_neighbor_image_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  import nns_pkg::*;

  // Covers any write or emit still in flight once the expected queue is empty.
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 1000;

  // One expected output transaction.
  typedef struct packed {
    logic [COLOR_W-1:0] pixel;
    logic               row_end;
    logic               frame_end;
  } scaled_px_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic                in_req_type   = REQ_WRITE;
  logic [ADDR_W-1:0]   in_byte_addr  = '0;
  logic [BYTE_W-1:0]   in_byte_data  = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [COLOR_W-1:0]  out_pixel;
  logic                out_row_end;
  logic                out_frame_end;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index     = '0;
  logic [CFG_DW-1:0]   cfg_data      = '0;

  nearest_neighbor_image_scaler dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_byte_addr  (in_byte_addr),
    .in_byte_data  (in_byte_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scaler model: image store, raster counters and register copies
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]  img_mem   [MEM_BYTES];
  bit                 img_valid [MEM_BYTES];   // store entries written so far
  logic [CNT_W-1:0]   col_pos   = '0;
  logic [CNT_W-1:0]   row_pos   = '0;
  logic [DIM_W-1:0]   out_w_reg = 9'd80;
  logic [DIM_W-1:0]   out_h_reg = 9'd60;
  logic [DIM_W-1:0]   src_w_reg = 9'd160;
  logic [DIM_W-1:0]   src_h_reg = 9'd120;
  logic               mode_reg  = MODE_GRAY;
  logic [COLOR_W-1:0] fg_reg    = 16'hFFFF;
  logic [COLOR_W-1:0] bg_reg    = 16'h0000;

  scaled_px_t pending_pixels[$];

  int  n_errors   = 0;
  int  n_writes   = 0;
  int  n_emits    = 0;
  int  n_checked  = 0;
  int  n_frames   = 0;
  int  n_cfg      = 0;
  int  n_settings = 0;
  bit  idle_on    = 1'b0;   // sender inserts gaps
  bit  stall_on   = 1'b0;   // receiver stalls
  int  stall_left = 0;

  // A zero dimension counts as 1, anything above MAX_DIM as MAX_DIM.
  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // Linear source pixel index for the current output position.
  function automatic int unsigned src_pixel_index();
    int unsigned r, c, sy, sx;
    r  = 32'(row_pos);
    c  = 32'(col_pos);
    sy = (r * eff_dim(src_h_reg)) / eff_dim(out_h_reg);
    sx = (c * eff_dim(src_w_reg)) / eff_dim(out_w_reg);
    return sy * eff_dim(src_w_reg) + sx;
  endfunction

  // Store byte the next emit reads, or -1 when it falls past the store.
  function automatic int next_read_addr();
    int unsigned idx;
    idx = src_pixel_index();
    if (mode_reg == MODE_BINARY) idx = idx >> 3;
    return (idx < MEM_BYTES) ? int'(idx) : -1;
  endfunction

  // Color and markers of the next output pixel; steps the raster counters.
  function automatic scaled_px_t scale_next_pixel();
    int unsigned idx, c, r;
    logic [BYTE_W-1:0] b;
    scaled_px_t px;
    idx = src_pixel_index();
    c   = 32'(col_pos);
    r   = 32'(row_pos);
    if (mode_reg == MODE_GRAY) begin
      b = (idx < MEM_BYTES) ? img_mem[idx] : '0;
      px.pixel = {b[7:3], b[7:2], b[7:3]};
    end else begin
      b = ((idx >> 3) < MEM_BYTES) ? img_mem[idx >> 3] : '0;
      px.pixel = b[3'd7 - idx[2:0]] ? fg_reg : bg_reg;
    end
    // Counters at or past their bound end the row / frame.
    px.row_end   = (c + 1 >= eff_dim(out_w_reg));
    px.frame_end = px.row_end && (r + 1 >= eff_dim(out_h_reg));
    if (px.row_end) begin
      col_pos = '0;
      row_pos = px.frame_end ? '0 : CNT_W'(r + 1);
    end else begin
      col_pos = CNT_W'(c + 1);
    end
    return px;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // One request transaction; valid stays up unless a gap follows.
  task automatic send_request(logic req, logic [ADDR_W-1:0] addr,
                              logic [BYTE_W-1:0] data);
    int gap;
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_byte_addr <= addr;
    in_byte_data <= data;
    do @(posedge clk); while (in_stall);
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_byte(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
    img_mem[addr]   = data;
    img_valid[addr] = 1'b1;
    n_writes++;
    send_request(REQ_WRITE, addr, data);
  endtask

  // Emit request. A never-written store byte is never read: if the next pixel
  // would land on one, fill it with a random byte first.
  task automatic emit_pixel();
    int a;
    a = next_read_addr();
    if (a >= 0 && !img_valid[a]) write_byte(ADDR_W'(a), BYTE_W'($urandom));
    pending_pixels.push_back(scale_next_pixel());
    n_emits++;
    // address and data are don't-care on an emit; keep them moving
    send_request(REQ_EMIT, ADDR_W'($urandom), BYTE_W'($urandom));
  endtask

  // Drop valid, wait for every pixel to come out, then let the block go quiet.
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write transaction; cfg_valid is left up for back-to-back writes.
  task automatic set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OUT_WIDTH:  out_w_reg = val[DIM_W-1:0];
      CFG_OUT_HEIGHT: out_h_reg = val[DIM_W-1:0];
      CFG_SRC_WIDTH:  src_w_reg = val[DIM_W-1:0];
      CFG_SRC_HEIGHT: src_h_reg = val[DIM_W-1:0];
      CFG_PIXEL_MODE: mode_reg  = val[0];
      CFG_FG_COLOR:   fg_reg    = val;
      CFG_BG_COLOR:   bg_reg    = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  // Full register setting, only ever applied to an idle block.
  task automatic configure(logic [CFG_DW-1:0] ow, logic [CFG_DW-1:0] oh,
                           logic [CFG_DW-1:0] sw, logic [CFG_DW-1:0] sh,
                           logic [CFG_DW-1:0] mode, logic [CFG_DW-1:0] fg,
                           logic [CFG_DW-1:0] bg);
    settle();
    set_reg(CFG_OUT_WIDTH,  ow);
    set_reg(CFG_OUT_HEIGHT, oh);
    set_reg(CFG_SRC_WIDTH,  sw);
    set_reg(CFG_SRC_HEIGHT, sh);
    set_reg(CFG_PIXEL_MODE, mode);
    set_reg(CFG_FG_COLOR,   fg);
    set_reg(CFG_BG_COLOR,   bg);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall pattern and the pixel checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (stall_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    scaled_px_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel transaction with none expected: pixel %h row_end %b frame_end %b",
                 $time, out_pixel, out_row_end, out_frame_end);
        n_errors++;
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (want.frame_end) n_frames++;
        if (out_pixel !== want.pixel) begin
          $display("%0t: pixel mismatch: expected %h actual %h",
                   $time, want.pixel, out_pixel);
          n_errors++;
        end
        if (out_row_end !== want.row_end) begin
          $display("%0t: row_end mismatch: expected %b actual %b",
                   $time, want.row_end, out_row_end);
          n_errors++;
        end
        if (out_frame_end !== want.frame_end) begin
          $display("%0t: frame_end mismatch: expected %b actual %b",
                   $time, want.frame_end, out_frame_end);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings (80x60 out of 160x120, gray). Gray extremes at the first
  // source pixels; the high addresses flip every address bit.
  task automatic test_reset_defaults();
    write_byte(15'h0000, 8'hFF);
    write_byte(15'h0002, 8'h00);
    write_byte(15'h7FFF, 8'hA5);
    write_byte(15'h5555, 8'h5A);
    write_byte(15'h2AAA, 8'hC3);
    repeat (3) emit_pixel();
  endtask

  // 1x1 frame: every pixel ends both row and frame. The column counter left over
  // from the previous frame sits past the new bound. Zero dims act as 1.
  task automatic test_tiny_frames();
    configure(16'd1, 16'd1, 16'd1, 16'd1, CFG_DW'(MODE_GRAY), 16'hFFFF, 16'h0000);
    repeat (2) emit_pixel();
    configure(16'd0, 16'd0, 16'd0, 16'd0, CFG_DW'(MODE_GRAY), 16'h0000, 16'hFFFF);
    repeat (2) emit_pixel();
  endtask

  // Shrink the window mid-frame: column and row both past the new bound.
  task automatic test_resize_mid_frame();
    configure(16'd4, 16'd4, 16'd8, 16'd8, CFG_DW'(MODE_GRAY), 16'hFFFF, 16'h0000);
    repeat (6) emit_pixel();
    configure(16'd2, 16'd1, 16'd8, 16'd8, CFG_DW'(MODE_GRAY), 16'hFFFF, 16'h0000);
    repeat (2) emit_pixel();
  endtask

  // Binary mode with alternating bits, both color registers in use.
  task automatic test_binary_mode();
    configure(16'd8, 16'd2, 16'd8, 16'd2, CFG_DW'(MODE_BINARY), 16'hF81F, 16'h07E0);
    write_byte(15'h0000, 8'hAA);
    write_byte(15'h0001, 8'h0F);
    repeat (4) emit_pixel();
  endtask

  // 320x320 source (one dim written as 511, clamped): the second output row
  // lands past the store and must read as zero.
  task automatic test_past_store();
    configure(16'd1, 16'd2, 16'h01FF, 16'd320, CFG_DW'(MODE_GRAY), 16'hFFFF, 16'h0000);
    repeat (3) emit_pixel();
  endtask

  // Full-width row at the largest width, binary mode, random image content.
  task automatic test_long_row();
    configure(16'd320, 16'd1, 16'd320, 16'h0141, CFG_DW'(MODE_BINARY),
              CFG_DW'($urandom), CFG_DW'($urandom));
    repeat (322) emit_pixel();
  endtask

  function automatic logic [CFG_DW-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CFG_DW'($urandom_range(1, 12));
    if (r < 85) return CFG_DW'($urandom_range(13, 64));
    if (r < 93) return CFG_DW'($urandom_range(65, 320));
    if (r < 97) return ($urandom_range(0, 1) != 0) ? 16'd0 : CFG_DW'($urandom_range(321, 511));
    return CFG_DW'($urandom);   // upper bits get masked off
  endfunction

  // Phases of random settings; within a phase mostly emits and image
  // rewrites inside the source region, plus stray writes anywhere.
  task automatic test_random_phases();
    int done, n, r, region;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      configure(rand_dim(), rand_dim(), rand_dim(), rand_dim(),
                CFG_DW'($urandom), CFG_DW'($urandom), CFG_DW'($urandom));
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      region = eff_dim(src_w_reg) * eff_dim(src_h_reg);
      if (mode_reg == MODE_BINARY) region = (region + 7) / 8;
      if (region > MEM_BYTES) region = MEM_BYTES;
      n = $urandom_range(20, 120);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 55) emit_pixel();
        else if (r < 85) write_byte(ADDR_W'($urandom_range(0, region - 1)),
                                    BYTE_W'($urandom));
        else write_byte(ADDR_W'($urandom), BYTE_W'($urandom));
      end
      done += n;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    idle_on  = 1'b1;
    stall_on = 1'b1;
    test_reset_defaults();
    test_tiny_frames();
    test_resize_mid_frame();
    test_binary_mode();
    test_past_store();
    test_long_row();
    test_random_phases();
    settle();
    $display("Covered %0d byte writes and %0d emits; %0d pixels checked, %0d frames ended.",
             n_writes, n_emits, n_checked, n_frames);
    $display("%0d register writes over %0d settings, gray and binary, dims 0 to 511.",
             n_cfg, n_settings);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5ms;
    $display("Timeout with %0d pixels still expected", pending_pixels.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
hdl/nns_pkg.sv
hdl/nearest_neighbor_image_scaler.sv
hdl/nns_checker.sv
dv/tb_nearest_neighbor_image_scaler.sv
